@@ src/hcbd_pkg.sv @@
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Character codes, end status codes, hex digit decode and the result record.
// ----------------------------------------------------------------------------
package hcbd_pkg;

  localparam int SIZE_BITS_DEFAULT   = 32;
  localparam int LENGTH_BITS_DEFAULT = 32;

  localparam logic [7:0] CH_CR   = 8'h0D;
  localparam logic [7:0] CH_LF   = 8'h0A;
  localparam logic [7:0] CH_0    = 8'h30;
  localparam logic [7:0] CH_9    = 8'h39;
  localparam logic [7:0] CH_LO_A = 8'h61;
  localparam logic [7:0] CH_LO_F = 8'h66;
  localparam logic [7:0] CH_UP_A = 8'h41;
  localparam logic [7:0] CH_UP_F = 8'h46;
  localparam logic [3:0] HEX_TEN = 4'd10;

  typedef enum logic [1:0] {
    ST_RAN_OUT = 2'd0,
    ST_ZERO    = 2'd1,
    ST_BAD     = 2'd2
  } status_t;

  typedef struct packed {
    logic        is_hex;
    logic [3:0]  value;
  } hex_t;

  typedef struct packed {
    logic        emit;
    logic [7:0]  out_byte;
    logic        byte_valid;
    logic        last_out;
    logic [31:0] decoded_length;
    status_t     end_status;
  } result_t;

  function automatic hex_t hex_digit(input logic [7:0] c);
    hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    if (c >= CH_0 && c <= CH_9) begin
      h.value = 4'(c - CH_0);
    end else if (c >= CH_LO_A && c <= CH_LO_F) begin
      h.value = 4'(c - CH_LO_A) + HEX_TEN;
    end else if (c >= CH_UP_A && c <= CH_UP_F) begin
      h.value = 4'(c - CH_UP_A) + HEX_TEN;
    end else begin
      h.is_hex = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ src/hcbd_parse.sv @@
// ----------------------------------------------------------------------------
// hcbd_parse: chunk framing state machine and counters
// Consumes one registered byte per step and forms the result record.
// ----------------------------------------------------------------------------
module hcbd_parse #(
  parameter int SIZE_BITS   = hcbd_pkg::SIZE_BITS_DEFAULT,
  parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              step,
  input  logic [7:0]        in_byte,
  input  logic              last_in,
  output hcbd_pkg::result_t res
);

  typedef enum logic [2:0] {
    PH_HEX,
    PH_EXT,
    PH_LINE_LF,
    PH_DATA,
    PH_AFTER,
    PH_TRAIL_LF,
    PH_STOP
  } phase_t;

  phase_t                   phase, phase_next;
  logic [SIZE_BITS-1:0]     chunk_count, chunk_count_next;
  logic [LENGTH_BITS-1:0]   emitted_count, emitted_count_next;
  hcbd_pkg::status_t        stop_reason, stop_reason_next;
  hcbd_pkg::hex_t           hx;
  logic [SIZE_BITS-1:0]     count_dec;
  logic                     data_byte;

  assign hx        = hcbd_pkg::hex_digit(in_byte);
  assign count_dec = chunk_count - 1'b1;

  always_comb begin
    phase_next         = phase;
    chunk_count_next   = chunk_count;
    emitted_count_next = emitted_count;
    stop_reason_next   = stop_reason;
    data_byte          = 1'b0;
    case (phase)
      PH_HEX, PH_AFTER: begin
        if (phase == PH_AFTER && in_byte == hcbd_pkg::CH_CR) begin
          phase_next = PH_TRAIL_LF;
        end else if (hx.is_hex) begin
          chunk_count_next = {chunk_count[SIZE_BITS-5:0], hx.value};
          phase_next       = PH_HEX;
        end else if (in_byte == hcbd_pkg::CH_CR) begin
          phase_next = PH_LINE_LF;
        end else begin
          phase_next = PH_EXT;
        end
      end
      PH_EXT: begin
        if (in_byte == hcbd_pkg::CH_CR) phase_next = PH_LINE_LF;
      end
      PH_LINE_LF: begin
        if (in_byte != hcbd_pkg::CH_LF) begin
          phase_next       = PH_STOP;
          stop_reason_next = hcbd_pkg::ST_BAD;
        end else if (chunk_count == '0) begin
          phase_next       = PH_STOP;
          stop_reason_next = hcbd_pkg::ST_ZERO;
        end else begin
          phase_next = PH_DATA;
        end
      end
      PH_DATA: begin
        data_byte        = 1'b1;
        chunk_count_next = count_dec;
        if (emitted_count != '1) emitted_count_next = emitted_count + 1'b1;
        if (count_dec == '0) phase_next = PH_AFTER;
      end
      PH_TRAIL_LF: begin
        if (in_byte == hcbd_pkg::CH_LF) begin
          chunk_count_next = '0;
          phase_next       = PH_HEX;
        end else begin
          phase_next       = PH_STOP;
          stop_reason_next = hcbd_pkg::ST_BAD;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    res.emit           = data_byte || last_in;
    res.out_byte       = data_byte ? in_byte : 8'd0;
    res.byte_valid     = data_byte;
    res.last_out       = last_in;
    res.decoded_length = 32'(emitted_count_next);
    if (!last_in) res.end_status = hcbd_pkg::ST_RAN_OUT;
    else if (phase_next == PH_STOP) res.end_status = stop_reason_next;
    else res.end_status = hcbd_pkg::ST_RAN_OUT;
  end

  // last item returns the parser to its reset state for the next body
  always_ff @(posedge clk) begin
    if (rst || (step && last_in)) begin
      phase         <= PH_HEX;
      chunk_count   <= '0;
      emitted_count <= '0;
      stop_reason   <= hcbd_pkg::ST_RAN_OUT;
    end else if (step) begin
      phase         <= phase_next;
      chunk_count   <= chunk_count_next;
      emitted_count <= emitted_count_next;
      stop_reason   <= stop_reason_next;
    end
  end

endmodule

@@ src/http_chunked_body_decoder.sv @@
// An accepted input item passes through the input register and then the result register to the output.
// Throughput: one byte per cycle while the output is not stalled; the parser step is a single registered pass.
// Bytes that carry no result (framing, size lines) retire without output.
// Reset (rst, synchronous): empties both registers and returns the parser to
// the size-line state with all counters zero; the last byte also resets the parser.
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked body decoder
// Input register, framing parser and result register; emits payload bytes
// plus a final item carrying the decoded length and end status.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder #(
  parameter int SIZE_BITS   = hcbd_pkg::SIZE_BITS_DEFAULT,
  parameter int LENGTH_BITS = hcbd_pkg::LENGTH_BITS_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  input  logic        last_in,
  // output channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte,
  output logic        byte_valid,
  output logic        last_out,
  output logic [31:0] decoded_length,
  output logic [1:0]  end_status
);

  // input register
  logic              s1_valid;
  logic [7:0]        s1_byte;
  logic              s1_last;
  logic              in_take;

  // parser step and result register handshake
  hcbd_pkg::result_t res;
  logic              out_free;
  logic              s1_go;
  logic              load_out;

  hcbd_parse #(
    .SIZE_BITS   (SIZE_BITS),
    .LENGTH_BITS (LENGTH_BITS)
  ) u_parse (
    .clk     (clk),
    .rst     (rst),
    .step    (s1_go),
    .in_byte (s1_byte),
    .last_in (s1_last),
    .res     (res)
  );

  // A held byte moves on when it makes no result, or when the result
  // register is empty or being drained this cycle.
  assign out_free = !out_valid || !out_stall;
  assign s1_go    = s1_valid && (!res.emit || out_free);
  assign load_out = s1_go && res.emit;
  assign in_stall = s1_valid && !s1_go;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte <= in_byte;
      s1_last <= last_in;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_byte       <= res.out_byte;
      byte_valid     <= res.byte_valid;
      last_out       <= res.last_out;
      decoded_length <= res.decoded_length;
      end_status     <= res.end_status;
    end
  end

`ifndef ASSERT_OFF
  // a result without a payload byte can only be the closing item
  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !byte_valid |-> last_out)
    else $error("result without payload byte is not last");

  // end status is only reported on the closing item
  a_status_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !last_out |-> end_status == hcbd_pkg::ST_RAN_OUT)
    else $error("end status on a non-last result");

  // stall only while a byte is held in the input register
  a_stall_held: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> s1_valid)
    else $error("input stalled with empty input register");

  // a drained result register empties unless refilled
  a_drain: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !load_out |=> !out_valid)
    else $error("result register did not empty after drain");
`endif

endmodule

@@ dv/http_chunked_body_decoder_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb: self-checking bench for the chunked decoder
// Feeds chunked bodies one byte per item, predicts every payload item and the
// closing length/status item, and compares each output item as it is taken.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb;

  localparam int CLK_HALF     = 2;          // 4 ns period
  localparam int RESET_CYCLES = 12;
  localparam int LATENCY      = 2;          // input item to output item
  localparam int SETTLE       = LATENCY + 6;
  localparam int DRAIN_LIMIT  = 4000;       // cycles allowed for results to land
  localparam int ITEM_TARGET  = 1000;       // random bytes to push
  localparam int TIMEOUT_NS   = 5_000_000;

  // Parser phases of the bench's own decoder copy
  typedef enum logic [2:0] {
    P_HEX,
    P_EXT,
    P_LINE_LF,
    P_DATA,
    P_AFTER,
    P_TRAIL_LF,
    P_STOP
  } parse_phase_t;

  // One predicted output item
  typedef struct {
    logic [7:0]        data;
    logic              valid;
    logic              last;
    logic [31:0]       length;
    hcbd_pkg::status_t status;
  } decode_result_t;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_byte   = 8'h00;
  logic        last_in   = 1'b0;
  logic        out_stall = 1'b0;
  logic        in_stall;
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        byte_valid;
  logic        last_out;
  logic [31:0] decoded_length;
  logic [1:0]  end_status;

  // Predicted items, oldest first
  decode_result_t expected_q[$];

  // Decoder copy: phase, size/remaining count, payload count, stop cause
  parse_phase_t      ph;
  logic [31:0]       remaining;
  logic [31:0]       emitted;
  hcbd_pkg::status_t stop_code;

  int  errors     = 0;
  int  items_sent = 0;
  bit  no_idle    = 1'b0;   // set for stretches with no gaps or stalls
  int  stall_left = 0;

  logic [7:0] body_q[$];

  http_chunked_body_decoder u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .last_in        (last_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_byte       (out_byte),
    .byte_valid     (byte_valid),
    .last_out       (last_out),
    .decoded_length (decoded_length),
    .end_status     (end_status)
  );

  always begin
    #(CLK_HALF) clk = 1'b1;
    #(CLK_HALF) clk = 1'b0;
  end

  // Gap length: mostly none, often short, now and then long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // ---------------------------------------------------------------------------
  // Decoder copy
  // ---------------------------------------------------------------------------
  task automatic clear_decoder();
    ph        = P_HEX;
    remaining = '0;
    emitted   = '0;
    stop_code = hcbd_pkg::ST_RAN_OUT;
  endtask

  function automatic bit hex_nibble(input logic [7:0] c, output logic [3:0] v);
    v = 4'd0;
    if (c >= hcbd_pkg::CH_0 && c <= hcbd_pkg::CH_9) begin
      v = c[3:0];
      return 1'b1;
    end
    // letters: low nibble 1..6 maps to 10..15 in both cases
    if ((c >= hcbd_pkg::CH_LO_A && c <= hcbd_pkg::CH_LO_F) ||
        (c >= hcbd_pkg::CH_UP_A && c <= hcbd_pkg::CH_UP_F)) begin
      v = c[3:0] + 4'd9;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic halt_parse(input hcbd_pkg::status_t why);
    ph        = P_STOP;
    stop_code = why;
  endtask

  // A size-line byte: hex shifts in (wrapping at 32 bits), CR waits for LF,
  // anything else opens the extension text
  task automatic size_char(input logic [7:0] c);
    logic [3:0] v;
    if (hex_nibble(c, v)) begin
      remaining = {remaining[27:0], v};
      ph        = P_HEX;
    end else if (c == hcbd_pkg::CH_CR) begin
      ph = P_LINE_LF;
    end else begin
      ph = P_EXT;
    end
  endtask

  task automatic decode_step(input logic [7:0] c, input logic l);
    logic           payload;
    decode_result_t r;
    payload = 1'b0;
    case (ph)
      P_HEX: size_char(c);
      P_EXT: if (c == hcbd_pkg::CH_CR) ph = P_LINE_LF;
      P_LINE_LF: begin
        if (c != hcbd_pkg::CH_LF) halt_parse(hcbd_pkg::ST_BAD);
        else if (remaining == '0) halt_parse(hcbd_pkg::ST_ZERO);
        else ph = P_DATA;
      end
      P_DATA: begin
        payload = 1'b1;
        if (emitted != '1) emitted = emitted + 1;
        remaining = remaining - 1;
        if (remaining == '0) ph = P_AFTER;
      end
      P_AFTER: begin
        if (c == hcbd_pkg::CH_CR) ph = P_TRAIL_LF;
        else size_char(c);
      end
      P_TRAIL_LF: begin
        if (c == hcbd_pkg::CH_LF) begin
          remaining = '0;
          ph        = P_HEX;
        end else begin
          halt_parse(hcbd_pkg::ST_BAD);
        end
      end
      default: ;  // stopped: ignore until the last byte
    endcase
    if (payload || l) begin
      r.data   = payload ? c : 8'h00;
      r.valid  = payload;
      r.last   = l;
      r.length = emitted;
      r.status = !l ? hcbd_pkg::ST_RAN_OUT :
                 (ph == P_STOP ? stop_code : hcbd_pkg::ST_RAN_OUT);
      expected_q.push_back(r);
    end
    if (l) clear_decoder();
  endtask

  // ---------------------------------------------------------------------------
  // Input side
  // ---------------------------------------------------------------------------
  // Drive one item at a falling edge, hold it until a rising edge takes it.
  // Valid stays high into the next call, which lowers it only for a gap.
  task automatic send_item(input logic [7:0] b, input logic l);
    int gap;
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    last_in  <= l;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_step(b, l);
    items_sent++;
  endtask

  task automatic send_text(input string s, input bit end_body);
    for (int i = 0; i < s.len(); i++) begin
      send_item(s[i], end_body && (i == s.len() - 1));
    end
  endtask

  // Stop sending and wait until every predicted item has come out
  task automatic wait_for_results();
    int w;
    @(negedge clk);
    in_valid <= 1'b0;
    w = 0;
    while (expected_q.size() != 0 && w < DRAIN_LIMIT) begin
      @(negedge clk);
      w++;
    end
    if (expected_q.size() != 0) begin
      $display("%0t: %0d expected items never arrived", $time, expected_q.size());
      errors++;
      expected_q.delete();
    end
    repeat (SETTLE) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Output side: random stall, checker
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
    end else if (no_idle || $urandom_range(0, 2) != 0) begin
      out_stall <= 1'b0;
      stall_left = $urandom_range(0, 6);
    end else begin
      out_stall <= 1'b1;
      stall_left = pick_gap();
    end
  end

  task automatic check_field(input string name, input logic [31:0] exp_v,
                             input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : check_results
    decode_result_t exp_r;
    if (!rst && out_valid === 1'b1 && out_stall == 1'b0) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected item, byte %h valid %b last %b", $time,
                 out_byte, byte_valid, last_out);
        errors++;
      end else begin
        exp_r = expected_q.pop_front();
        check_field("out_byte", 32'(exp_r.data), 32'(out_byte));
        check_field("byte_valid", 32'(exp_r.valid), 32'(byte_valid));
        check_field("last_out", 32'(exp_r.last), 32'(last_out));
        check_field("decoded_length", exp_r.length, decoded_length);
        check_field("end_status", 32'(exp_r.status), 32'(end_status));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Random body builder
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return hcbd_pkg::CH_0 + 8'(v);
    return ($urandom_range(0, 1) ? hcbd_pkg::CH_UP_A : hcbd_pkg::CH_LO_A) +
           8'(v - 4'd10);
  endfunction

  // Size line: minimal digits, sometimes padded, sometimes an extra leading
  // digit that falls off the 32-bit accumulator; optional extension; CRLF
  task automatic add_size_line(input logic [31:0] size);
    int ndig;
    ndig = 1;
    while (ndig < 8 && (size >> (4 * ndig)) != 0) ndig++;
    if (size == 0 && $urandom_range(0, 3) == 0) begin
      ndig = 0;                                  // empty line reads as zero
    end else if ($urandom_range(0, 7) == 0) begin
      body_q.push_back(hex_char(4'($urandom_range(1, 15))));
      ndig = 8;
    end else begin
      repeat ($urandom_range(0, 2)) body_q.push_back(hcbd_pkg::CH_0);
    end
    for (int d = ndig - 1; d >= 0; d--) body_q.push_back(hex_char(size[4*d +: 4]));
    if ($urandom_range(0, 3) == 0) begin
      body_q.push_back(8'h3B);                   // ';'
      repeat ($urandom_range(1, 6)) begin
        logic [7:0] e;
        e = 8'($urandom_range(0, 255));
        body_q.push_back(e == hcbd_pkg::CH_CR ? 8'h3D : e);
      end
    end
    body_q.push_back(hcbd_pkg::CH_CR);
    body_q.push_back(hcbd_pkg::CH_LF);
  endtask

  function automatic logic [7:0] noise_byte();
    case ($urandom_range(0, 4))
      0: return hcbd_pkg::CH_CR;
      1: return hcbd_pkg::CH_LF;
      2: return hex_char(4'($urandom_range(0, 15)));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic build_body();
    int          mode;
    int unsigned size;
    int          cut;
    body_q.delete();
    mode = $urandom_range(0, 99);
    if (mode >= 90) begin
      // plain noise
      repeat ($urandom_range(1, 16)) body_q.push_back(noise_byte());
      return;
    end
    if ($urandom_range(0, 29) == 0) begin
      // huge declared size, data cut short by the last byte
      add_size_line(32'hFFFF_FFFF - $urandom_range(0, 15));
      repeat ($urandom_range(1, 10)) body_q.push_back(8'($urandom_range(0, 255)));
      return;
    end
    repeat ($urandom_range(0, 4)) begin
      size = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      add_size_line(size);
      repeat (size) body_q.push_back(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 4) != 0) begin
        body_q.push_back(hcbd_pkg::CH_CR);
        body_q.push_back(hcbd_pkg::CH_LF);
      end
    end
    add_size_line(32'd0);
    if ($urandom_range(0, 2) == 0) begin
      repeat ($urandom_range(1, 3)) body_q.push_back(noise_byte());
    end
    // broken framing: one byte replaced
    if (mode >= 75) begin
      body_q[$urandom_range(0, body_q.size() - 1)] = noise_byte();
    end
    // input runs out early
    if ($urandom_range(0, 4) == 0) begin
      cut = $urandom_range(1, body_q.size());
      while (body_q.size() > cut) void'(body_q.pop_back());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Extension text, payload bytes 00 and FF, a size digit right after data
  // with no CRLF, then a zero chunk
  task automatic test_extension_and_extremes();
    send_text("2;x\r\n", 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_text("0\r\n", 1'b1);
  endtask

  // Empty size line is size zero
  task automatic test_empty_size_line();
    send_text("\r\n", 1'b1);
  endtask

  // CR on a size line without LF, then bytes ignored until last
  task automatic test_size_line_missing_lf();
    send_text("1\rQR", 1'b1);
  endtask

  // CR after chunk data without LF
  task automatic test_trailer_missing_lf();
    send_text("1\r\na\rx", 1'b1);
  endtask

  // Last byte lands inside data: payload and closing item in one
  task automatic test_truncated_data();
    send_text("A\r\n", 1'b0);
    send_item(8'h7A, 1'b1);
  endtask

  // Sender holds off mid-chunk until the output has caught up
  task automatic test_pause_mid_data();
    send_text("8\r\nabcd", 1'b0);
    wait_for_results();
    send_text("efgh\r\n0\r\n\r\n", 1'b1);
  endtask

  task automatic test_random_bodies();
    int start;
    start = items_sent;
    while (items_sent - start < ITEM_TARGET) begin
      build_body();
      no_idle = ($urandom_range(0, 9) == 0);
      foreach (body_q[i]) send_item(body_q[i], i == body_q.size() - 1);
      no_idle = 1'b0;
    end
  endtask

  initial begin
    clear_decoder();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_extension_and_extremes();
    test_empty_size_line();
    test_size_line_missing_lf();
    test_trailer_missing_lf();
    test_truncated_data();
    test_pause_mid_data();
    test_random_bodies();
    wait_for_results();

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #(TIMEOUT_NS);
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
